>>> rtl/tvg_pkg.sv
// ----------------------------------------------------------------------------
// tvg_pkg
// Shared types, constants and control structs for the TV gradient stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package tvg_pkg;

  localparam int MAX_SIDE_DEF = 256;
  localparam int SIDE_CAP     = 256;   // size registers are 9 bits
  localparam int ROOT_STEPS   = 29;    // result bits of floor(sqrt(S << 24))
  localparam int DIV_STEPS    = 43;    // dividend bits of |n| << 24
  localparam int STEP_W       = 6;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_EPS  = 2'd2;

  // the three quotient terms
  localparam logic [1:0] TERM_CENTER = 2'd0;
  localparam logic [1:0] TERM_DOWN   = 2'd1;
  localparam logic [1:0] TERM_RIGHT  = 2'd2;

  typedef struct packed {
    logic signed [15:0] pixel;
    logic               drain;
  } pix_t;

  typedef struct packed {
    logic signed [15:0] gradient;
    logic [7:0]         row_index;
    logic [7:0]         col_index;
    logic               last;
  } res_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       term_setup;
    logic       sq_a;
    logic       sq_b;
    logic       sq_c;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       acc_clear;
    logic       acc_add;
    logic       finish;
    logic [1:0] term;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic root_zero;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/tv_gradient_stencil_top.sv
// Sequence: a word that completes a pixel is taken, loaded, then runs 3 terms
// (setup, three squares, 29-step root, 43-step divide, add), then finish. A
// term with a zero root skips the divide. Finish waits while an earlier result
// word is stalled.
// Throughput: one word at a time; a new word is taken only once the last one is done.
// Reset (rst, synchronous): position to (0,0), window cleared, sizes 256,
// eps_sq 1; line buffers are not cleared.
// ----------------------------------------------------------------------------
// tv_gradient_stencil_top
// Streaming smoothed total-variation gradient over a 3x3 window.
// ----------------------------------------------------------------------------
`default_nettype none

module tv_gradient_stencil_top import tvg_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pix_valid,
  output logic             pix_ready,
  input  wire pix_t        pix,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tvg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tvg_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .pix       (pix),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

>>> rtl/tvg_ctrl.sv
// ----------------------------------------------------------------------------
// tvg_ctrl
// Sequencer: takes one word and loads the window; if the word completes a
// pixel, runs the three quotient terms through the shared square, root and divide steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tvg_ctrl import tvg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pix_valid,
  output logic      pix_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_TERM  = 4'd2;
  localparam logic [3:0] S_SQA   = 4'd3;
  localparam logic [3:0] S_SQB   = 4'd4;
  localparam logic [3:0] S_SQC   = 4'd5;
  localparam logic [3:0] S_RINIT = 4'd6;
  localparam logic [3:0] S_ROOT  = 4'd7;
  localparam logic [3:0] S_DINIT = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic [1:0]        term, term_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      term  <= TERM_CENTER;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      term  <= term_next;
    end
  end

  assign pix_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    term_next  = term;
    cmd        = '0;
    cmd.term   = term;
    unique case (state)
      S_IDLE: begin
        if (pix_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (sts.hit) begin
          cmd.acc_clear = 1'b1;
          term_next     = TERM_CENTER;
          state_next    = S_TERM;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TERM: begin
        cmd.term_setup = 1'b1;
        state_next     = S_SQA;
      end
      S_SQA: begin
        cmd.sq_a   = 1'b1;
        state_next = S_SQB;
      end
      S_SQB: begin
        cmd.sq_b   = 1'b1;
        state_next = S_SQC;
      end
      S_SQC: begin
        cmd.sq_c   = 1'b1;
        state_next = S_RINIT;
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == STEP_W'(ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_DINIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        // zero root: quotient stays zero
        state_next   = sts.root_zero ? S_ACC : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_ACC;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        if (term == TERM_RIGHT) begin
          state_next = S_FIN;
        end else begin
          term_next  = term + 1'b1;
          state_next = S_TERM;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/tvg_dp.sv
// ----------------------------------------------------------------------------
// tvg_dp
// Datapath: config registers, stream position, line buffers, 3x3 window,
// shared squarer, bit-pair root, restoring divider, accumulator, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module tvg_dp import tvg_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire pix_t        pix,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res
);

  localparam int LIM = (MAX_SIDE < SIDE_CAP) ? MAX_SIDE : SIDE_CAP;
  localparam int LAW = $clog2(LIM);

  function automatic logic [8:0] eff_side(input logic [8:0] r);
    logic [8:0] v;
    v = r;
    if (v == 9'd0) v = 9'd1;
    if (v > 9'(LIM)) v = 9'(LIM);
    return v;
  endfunction

  function automatic logic signed [19:0] ext20(input logic signed [15:0] x);
    return {{4{x[15]}}, x};
  endfunction

  logic [8:0]  rows_reg, cols_reg;
  logic [15:0] eps_reg;
  logic [8:0]  rows, cols;
  logic [8:0]  pos_row, pos_col;

  assign rows = eff_side(rows_reg);
  assign cols = eff_side(cols_reg);

  // line buffers
  logic signed [15:0] mem_above [LIM];
  logic signed [15:0] mem_mid   [LIM];
  logic signed [15:0] rd_above, rd_mid, pix_v;
  logic [LAW-1:0]     addr;

  assign addr = pos_col[LAW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_above <= mem_above[addr];
      rd_mid   <= mem_mid[addr];
    end
    if (cmd.load) begin
      mem_above[addr] <= rd_mid;
      mem_mid[addr]   <= pix_v;
    end
  end

  // which pixel completes with this word
  logic       hit;
  logic [8:0] tr_c, tc_c;
  logic [8:0] tr, tc;

  always_comb begin
    if (pos_col != 9'd0) begin
      hit  = (pos_row != 9'd0);
      tr_c = pos_row - 9'd1;
      tc_c = pos_col - 9'd1;
    end else begin
      hit  = (pos_row >= 9'd2);
      tr_c = pos_row - 9'd2;
      tc_c = cols - 9'd1;
    end
    if (tr_c >= rows) hit = 1'b0;
  end

  logic signed [15:0] win [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg <= 9'd256;
      cols_reg <= 9'd256;
      eps_reg  <= 16'd1;
      pos_row  <= '0;
      pos_col  <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS: begin
            rows_reg <= cfg_data[8:0];
            pos_row  <= '0;
            pos_col  <= '0;
          end
          REG_COLS: begin
            cols_reg <= cfg_data[8:0];
            pos_row  <= '0;
            pos_col  <= '0;
          end
          REG_EPS: eps_reg <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        for (int k = 0; k < 3; k++) begin
          win[k][0] <= win[k][1];
          win[k][1] <= win[k][2];
        end
        win[0][2] <= rd_above;
        win[1][2] <= rd_mid;
        win[2][2] <= pix_v;
        if ({1'b0, pos_row} >= {1'b0, rows} + 10'd1) begin
          pos_row <= '0;
          pos_col <= '0;
        end else if (pos_col + 9'd1 >= cols) begin
          pos_col <= '0;
          pos_row <= pos_row + 9'd1;
        end else begin
          pos_col <= pos_col + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      // drain word or past the last row: a zero pixel
      pix_v <= (pix.drain || pos_row >= rows) ? 16'sd0 : pix.pixel;
    end
    if (cmd.load) begin
      tr <= tr_c;
      tc <= tc_c;
    end
  end

  // neighbors, zero outside the image
  logic up_ok, left_ok, down_ok, right_ok;
  logic signed [19:0] p, u, l, d, dl, rt, ur;
  logic signed [19:0] n_c, a_c, b_c;

  always_comb begin
    up_ok    = (tr != 9'd0);
    left_ok  = (tc != 9'd0);
    down_ok  = ({1'b0, tr} + 10'd1) < {1'b0, rows};
    right_ok = ({1'b0, tc} + 10'd1) < {1'b0, cols};
    p  = ext20(win[1][1]);
    u  = up_ok ? ext20(win[0][1]) : 20'sd0;
    l  = left_ok ? ext20(win[1][0]) : 20'sd0;
    d  = down_ok ? ext20(win[2][1]) : 20'sd0;
    dl = (down_ok && left_ok) ? ext20(win[2][0]) : 20'sd0;
    rt = right_ok ? ext20(win[1][2]) : 20'sd0;
    ur = (up_ok && right_ok) ? ext20(win[0][2]) : 20'sd0;
    unique case (cmd.term)
      TERM_CENTER: begin
        n_c = (p <<< 2) - (u <<< 1) - (l <<< 1);
        a_c = p - u;
        b_c = p - l;
      end
      TERM_DOWN: begin
        n_c = (p - d) <<< 1;
        a_c = d - p;
        b_c = d - dl;
      end
      default: begin
        n_c = (p - rt) <<< 1;
        a_c = rt - p;
        b_c = rt - ur;
      end
    endcase
  end

  logic signed [19:0] n_reg;
  logic signed [16:0] a_reg, b_reg, mul_in;
  logic signed [33:0] sq;
  logic [32:0]        prod;
  logic [33:0]        s;

  assign mul_in = cmd.sq_a ? a_reg : b_reg;
  assign sq     = mul_in * mul_in;

  // root: two radicand bits per step
  logic [57:0] sx;
  logic [31:0] srem, srem_sh, strial;
  logic [28:0] sroot;

  assign srem_sh = {srem[29:0], sx[57:56]};
  assign strial  = {1'b0, sroot, 2'b01};

  // divider: one quotient bit per step
  logic [42:0] dv;
  logic [28:0] drem;
  logic [29:0] drem_sh;
  logic [30:0] q;
  logic [19:0] mag20;

  assign drem_sh = {drem, dv[42]};
  assign mag20   = n_reg[19] ? 20'(-n_reg) : 20'(n_reg);

  logic signed [33:0] acc, qext;

  assign qext = n_reg[19] ? -$signed({3'b000, q}) : $signed({3'b000, q});

  always_ff @(posedge clk) begin
    if (cmd.term_setup) begin
      n_reg <= n_c;
      a_reg <= a_c[16:0];
      b_reg <= b_c[16:0];
    end
    if (cmd.sq_a) begin
      prod <= sq[32:0];
      s    <= {18'd0, eps_reg};
    end
    if (cmd.sq_b) begin
      prod <= sq[32:0];
      s    <= s + {1'b0, prod};
    end
    if (cmd.sq_c) begin
      s <= s + {1'b0, prod};
    end
    if (cmd.root_init) begin
      sx    <= {s, 24'd0};
      srem  <= '0;
      sroot <= '0;
    end
    if (cmd.root_step) begin
      sx <= {sx[55:0], 2'b00};
      if (srem_sh >= strial) begin
        srem  <= srem_sh - strial;
        sroot <= {sroot[27:0], 1'b1};
      end else begin
        srem  <= srem_sh;
        sroot <= {sroot[27:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      dv   <= {mag20[18:0], 24'd0};
      drem <= '0;
      q    <= '0;
    end
    if (cmd.div_step) begin
      dv <= {dv[41:0], 1'b0};
      if (drem_sh >= {1'b0, sroot}) begin
        drem <= 29'(drem_sh - {1'b0, sroot});
        q    <= {q[29:0], 1'b1};
      end else begin
        drem <= drem_sh[28:0];
        q    <= {q[29:0], 1'b0};
      end
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + qext;
    end
  end

  // output register
  logic signed [15:0] sat;

  always_comb begin
    if (acc > 34'sd32767) sat = 16'sh7fff;
    else if (acc < -34'sd32768) sat = -16'sh8000;
    else sat = acc[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.gradient  <= sat;
      res.row_index <= tr[7:0];
      res.col_index <= tc[7:0];
      res.last      <= (tr == rows - 9'd1) && (tc == cols - 9'd1);
    end
  end

  assign sts.hit       = hit;
  assign sts.root_zero = (sroot == '0);
  assign sts.out_busy  = res_valid && !res_ready;

endmodule

`default_nettype wire

>>> rtl/tvg_check.sv
// ----------------------------------------------------------------------------
// tvg_check
// Port-level checks for the TV gradient stencil, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tvg_check import tvg_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pix_valid,
  input wire logic        pix_ready,
  input wire pix_t        pix,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire res_t        res,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [1:0]  cfg_index,
  input wire logic [15:0] cfg_data
);

  // a waiting result word stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word dropped or changed while stalled");

  // one word in flight: no accept right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> !pix_ready)
    else $error("input taken while a word is in work");

  // a result never shows up the cycle after an accept
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> !$rose(res_valid))
    else $error("result too early");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind tv_gradient_stencil_top tvg_check u_check (.*);

`default_nettype wire
